### rtl/tpms_pkg.sv
// ----------------------------------------------------------------------------
// tpms_pkg
// Shared widths, register indexes and reset values for the period-based
// tachometer with median-of-ring speed filter.
// ----------------------------------------------------------------------------
package tpms_pkg;

  localparam int PERIOD_W   = 17;
  localparam int SPEED_W    = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam int DEF_RING_DEPTH = 5;
  localparam int DEF_GROUP_SIZE = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONSTANT = 2'd2;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST     = 17'd390;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST     = 17'd78125;
  localparam logic [SPEED_W-1:0]  SPEED_CONSTANT_RST = 18'd78125;

  // handshake between the sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### rtl/tpms_sdiv.sv
// ----------------------------------------------------------------------------
// tpms_sdiv
// Restoring bit-serial divider: one quotient bit per cycle, MSB first.
// Shared between the group average and the speed division.
// ----------------------------------------------------------------------------
module tpms_sdiv
  import tpms_pkg::*;
#(
  parameter int DVD_W = 19,
  parameter int DVS_W = PERIOD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  unit_ctl_t        ctl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output unit_sts_t        sts,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] dq;        // dividend shifts out, quotient shifts in
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, dq[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dq  <= {dq[DVD_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = dq;

endmodule

### rtl/tpms_median.sv
// ----------------------------------------------------------------------------
// tpms_median
// Bit-serial rank selection over a copy of the ring: MSB first, keeps the
// candidates that can still hold the median rank. The ring is not reordered.
// ----------------------------------------------------------------------------
module tpms_median
  import tpms_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  unit_ctl_t           ctl,
  input  logic [PERIOD_W-1:0] ring [RING_DEPTH],
  output unit_sts_t           sts,
  output logic [PERIOD_W-1:0] median
);

  localparam int RK_W = $clog2(RING_DEPTH + 1);
  localparam logic [RK_W-1:0] RANK = RK_W'((RING_DEPTH + 1) / 2 - 1);
  localparam int CNT_W = $clog2(PERIOD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PERIOD_W - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [PERIOD_W-1:0]   scratch [RING_DEPTH];
  logic [RING_DEPTH-1:0] cand;
  logic [RK_W-1:0]       rank;

  logic [RING_DEPTH-1:0] msb;
  logic [RING_DEPTH-1:0] zeros;
  logic [RK_W-1:0]       n_zero;
  logic                  take_zero;

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      msb[i] = scratch[i][PERIOD_W-1];
    end
    zeros  = cand & ~msb;
    n_zero = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      n_zero = n_zero + RK_W'(zeros[i]);
    end
    take_zero = n_zero > rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        scratch[i] <= ring[i];
      end
      cand <= '1;
      rank <= RANK;
    end else if (busy) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        scratch[i] <= {scratch[i][PERIOD_W-2:0], 1'b0};
      end
      if (take_zero) begin
        cand <= zeros;
      end else begin
        cand <= cand & msb;
        rank <= rank - n_zero;
      end
      median <= {median[PERIOD_W-2:0], ~take_zero};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

### rtl/tachometer_period_median_speed_core.sv
// ----------------------------------------------------------------------------
// tachometer_period_median_speed_core
// Period filter, group averaging, ring of averages, median and speed division.
//
//   channel  dir  signals                                   transfer when
//   in       in   in_valid, in_stall, period_ticks          in_valid & !in_stall
//   out      out  out_valid, out_stall, speed_rpm,           out_valid & !out_stall
//                 median_period, speed_valid
//   cfg      in   cfg_we, cfg_index, cfg_data               cfg_we
//
// A rejected period or one that does not close a group leaves the sequencer idle.
// A group-closing period runs the average division, the median and the speed
// division in turn on the shared serial divider (DVD_W = max(sum width, 18))
// and the bit-serial median, then loads the output register; the speed
// division is skipped when the median is zero.
// in_stall is high while a result is in progress; the output register lets
// the next item in while a result waits. Synchronous reset clears the ring.
// ----------------------------------------------------------------------------
module tachometer_period_median_speed_core
  import tpms_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PERIOD_W-1:0]   period_ticks,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SPEED_W-1:0]    speed_rpm,
  output logic [PERIOD_W-1:0]   median_period,
  output logic                  speed_valid
);

  localparam int SUM_W = PERIOD_W + $clog2(GROUP_SIZE);
  localparam int DVD_W = (SUM_W > SPEED_W) ? SUM_W : SPEED_W;
  localparam int CNT_W = $clog2(GROUP_SIZE + 1);
  localparam int POS_W = $clog2(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(RING_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AVG   = 3'd1;
  localparam logic [2:0] ST_MEDGO = 3'd2;
  localparam logic [2:0] ST_MED   = 3'd3;
  localparam logic [2:0] ST_SPD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;

  logic [PERIOD_W-1:0]  min_period;
  logic [PERIOD_W-1:0]  max_period;
  logic [SPEED_W-1:0]   speed_constant;

  logic [PERIOD_W-1:0]  ring [RING_DEPTH];
  logic [POS_W-1:0]     ring_write_pos;
  logic [CNT_W-1:0]     group_count;
  logic [SUM_W-1:0]     period_sum;

  logic                 in_xfer;
  logic                 in_ok;
  logic                 group_end;
  logic [SUM_W-1:0]     sum_plus;
  logic                 out_free;

  unit_ctl_t            div_ctl;
  unit_sts_t            div_sts;
  logic [DVD_W-1:0]     div_dividend;
  logic [PERIOD_W-1:0]  div_divisor;
  logic [DVD_W-1:0]     div_q;

  unit_ctl_t            med_ctl;
  unit_sts_t            med_sts;
  logic [PERIOD_W-1:0]  med_val;
  logic                 med_zero;

  assign in_stall  = state != ST_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  assign in_ok     = period_ticks >= min_period && period_ticks <= max_period;
  assign group_end = group_count == CNT_LAST;
  assign sum_plus  = period_sum + SUM_W'(period_ticks);
  assign out_free  = !out_valid || !out_stall;
  assign med_zero  = med_val == '0;

  // sequencer
  always_comb begin
    state_next        = state;
    div_ctl.start     = 1'b0;
    med_ctl.start     = 1'b0;
    div_dividend      = DVD_W'(sum_plus);
    div_divisor       = PERIOD_W'(GROUP_SIZE);
    case (state)
      ST_IDLE: begin
        if (in_xfer && in_ok && group_end) begin
          div_ctl.start = 1'b1;
          state_next    = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_sts.done) state_next = ST_MEDGO;
      end
      ST_MEDGO: begin
        med_ctl.start = 1'b1;
        state_next    = ST_MED;
      end
      ST_MED: begin
        if (med_sts.done) begin
          if (med_zero) begin
            state_next = ST_OUT;
          end else begin
            div_ctl.start = 1'b1;
            div_dividend  = DVD_W'(speed_constant);
            div_divisor   = med_val;
            state_next    = ST_SPD;
          end
        end
      end
      ST_SPD: begin
        if (div_sts.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period     <= MIN_PERIOD_RST;
      max_period     <= MAX_PERIOD_RST;
      speed_constant <= SPEED_CONSTANT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_PERIOD:     min_period     <= cfg_data[PERIOD_W-1:0];
        REG_MAX_PERIOD:     max_period     <= cfg_data[PERIOD_W-1:0];
        REG_SPEED_CONSTANT: speed_constant <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // group accumulation and ring of averages
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count    <= '0;
      period_sum     <= '0;
      ring_write_pos <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (in_xfer && in_ok && !group_end) begin
        group_count <= group_count + 1'b1;
        period_sum  <= sum_plus;
      end
      if (state == ST_AVG && div_sts.done) begin
        ring[ring_write_pos] <= div_q[PERIOD_W-1:0];
        ring_write_pos <= (ring_write_pos == POS_LAST) ? '0 : ring_write_pos + 1'b1;
        group_count    <= '0;
        period_sum     <= '0;
      end
    end
  end

  tpms_sdiv #(
    .DVD_W (DVD_W),
    .DVS_W (PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  tpms_median #(
    .RING_DEPTH (RING_DEPTH)
  ) u_median (
    .clk    (clk),
    .rst    (rst),
    .ctl    (med_ctl),
    .ring   (ring),
    .sts    (med_sts),
    .median (med_val)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      speed_rpm     <= med_zero ? '0 : div_q[SPEED_W-1:0];
      median_period <= med_val;
      speed_valid   <= !med_zero;
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result shown without finishing the sequence");

  a_valid_median: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_valid == (median_period != '0)))
    else $error("speed_valid disagrees with median");

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !speed_valid) |-> speed_rpm == '0)
    else $error("speed nonzero with zero median");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_write_pos <= POS_LAST && group_count <= CNT_LAST)
    else $error("ring position or group count out of range");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_sts.busy && !med_sts.busy)
    else $error("serial unit busy while the sequencer is idle");
`endif

endmodule
